>>> src/lrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrs_pkg;

  localparam int unsigned MAX_DIM     = 64;
  localparam int unsigned SIG_ENTRIES = 256;
  localparam int unsigned ACC_W       = 38;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_FEATURE = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DIMENSION  = 2'd0,
    REG_BIAS       = 2'd1,
    REG_RAW_OUTPUT = 2'd2
  } cfg_reg_e;

  // feature beat entering the multiply stage
  typedef struct packed {
    logic signed [15:0] value;
    logic               active;
    logic               last;
    logic               err;
  } feat_t;

  // finished vector sum
  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic                    err;
  } sum_t;

  typedef logic [SIG_ENTRIES-1:0][15:0] sig_table_t;

  // shift-subtract division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // T[k] = s(k/32) in Q0.16
  function automatic sig_table_t build_sig_table();
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e32;
    logic [63:0] p;
    logic [63:0] den;
    logic [63:0] t;
    sig_table_t  tab;
    term = 64'd1 << 60;
    sum  = term;
    for (int n = 1; n <= 8; n++) begin
      term = udiv64(term >> 5, 64'(n));
      if ((n & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    e32 = (sum + (64'd1 << 27)) >> 28;
    p   = 64'd1 << 32;
    for (int k = 0; k < SIG_ENTRIES; k++) begin
      den    = (64'd1 << 32) + p;
      t      = udiv64((64'd1 << 48) + (den >> 1), den);
      tab[k] = t[15:0];
      p      = (p * e32 + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

`default_nettype wire

>>> src/lrs_coef_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module lrs_coef_mem #(
  parameter int unsigned Depth = lrs_pkg::MAX_DIM,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic signed [15:0]      wdata_i,
  input  logic                    re_i,
  input  logic [AddrW-1:0]        raddr_i,
  output logic signed [15:0]      rdata_o
);

  logic signed [15:0] mem_q [Depth];
  logic signed [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/lrs_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module lrs_mac (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lrs_pkg::feat_t        in_i,
  input  logic signed [15:0]    coef_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lrs_pkg::sum_t         out_o
);

  import lrs_pkg::*;

  logic                    s2_valid_q;
  logic signed [31:0]      prod_q;
  logic signed [31:0]      prod_d;
  logic                    s2_last_q;
  logic                    s2_err_q;
  logic                    s2_ready;
  logic                    s2_fire;
  logic                    in_fire;
  logic signed [ACC_W-1:0] acc_q;
  logic [ACC_W:0]          sum;
  logic [ACC_W-1:0]        acc_sat;
  logic                    s3_valid_q;
  logic                    s3_ready;
  sum_t                    s3_q;

  assign s3_ready   = !s3_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || !s2_last_q || s3_ready;
  assign s2_fire    = s2_valid_q && s2_ready;
  assign in_ready_o = s2_ready;
  assign in_fire    = in_valid_i && s2_ready;

  always_comb begin
    if (in_i.active) begin
      prod_d = in_i.value * coef_i;
    end else begin
      prod_d = '0;
    end
  end

  assign sum = {acc_q[ACC_W-1], acc_q} + {{(ACC_W + 1 - 32){prod_q[31]}}, prod_q};

  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_sat = sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      acc_sat = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= in_valid_i;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_fire && s2_last_q;
      end
      if (s2_fire) begin
        acc_q <= s2_last_q ? '0 : acc_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      prod_q    <= prod_d;
      s2_last_q <= in_i.last;
      s2_err_q  <= in_i.err;
    end
    if (s2_fire && s2_last_q) begin
      s3_q.acc <= acc_sat;
      s3_q.err <= s2_err_q;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_o       = s3_q;

  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire && s2_last_q |=> acc_q == '0)
    else $error("accumulator not cleared after end of vector");

endmodule

`default_nettype wire

>>> src/lrs_post.sv
`timescale 1ns / 1ps
`default_nettype none

module lrs_post (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lrs_pkg::sum_t         in_i,
  input  logic signed [31:0]    bias_i,
  input  logic                  raw_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           score_o,
  output logic                  err_o
);

  import lrs_pkg::*;

  logic               s4_valid_q;
  logic               s4_ready;
  logic signed [31:0] s4_score_q;
  logic               s4_err_q;
  logic [ACC_W:0]     bsum;
  logic               bsum_ovf;
  logic [31:0]        score_d;

  logic               s5_valid_q;
  logic               s5_ready;
  logic [31:0]        s5_score_q;
  logic               s5_neg_q;
  logic               s5_over_q;
  logic [7:0]         s5_k_q;
  logic               s5_err_q;
  logic [32:0]        mag;

  logic               out_valid_q;
  logic               out_ready;
  logic               out_load;
  logic [31:0]        out_score_q;
  logic               out_err_q;
  logic [15:0]        tab;
  logic [16:0]        sig;
  logic [31:0]        out_score_d;

  assign out_ready  = !out_valid_q || out_ready_i;
  assign s5_ready   = !s5_valid_q || out_ready;
  assign s4_ready   = !s4_valid_q || s5_ready;
  assign in_ready_o = s4_ready;
  assign out_load   = s5_valid_q && out_ready;

  // bias add, saturate to 32 bits
  assign bsum     = {in_i.acc[ACC_W-1], in_i.acc} + {{(ACC_W + 1 - 32){bias_i[31]}}, bias_i};
  assign bsum_ovf = !((&bsum[ACC_W:31]) || !(|bsum[ACC_W:31]));

  always_comb begin
    if (bsum_ovf) begin
      score_d = bsum[ACC_W] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      score_d = bsum[31:0];
    end
  end

  // |x| in Q16.16; bits 18:11 index the table in steps of 1/32
  assign mag = s4_score_q[31] ? (33'd0 - {1'b1, s4_score_q}) : {1'b0, s4_score_q};

  assign tab = SIG_TABLE[s5_k_q];

  always_comb begin
    if (s5_over_q) begin
      sig = s5_neg_q ? 17'd0 : 17'h0ffff;
    end else if (s5_neg_q) begin
      sig = 17'h10000 - {1'b0, tab};
    end else begin
      sig = {1'b0, tab};
    end
    out_score_d = raw_i ? s5_score_q : {15'd0, sig};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s4_ready) begin
        s4_valid_q <= in_valid_i;
      end
      if (s5_ready) begin
        s5_valid_q <= s4_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s5_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s4_ready) begin
      s4_score_q <= score_d;
      s4_err_q   <= in_i.err;
    end
    if (s4_valid_q && s5_ready) begin
      s5_score_q <= s4_score_q;
      s5_neg_q   <= s4_score_q[31];
      s5_over_q  <= |mag[32:19];
      s5_k_q     <= mag[18:11];
      s5_err_q   <= s4_err_q;
    end
    if (out_load) begin
      out_score_q <= out_score_d;
      out_err_q   <= s5_err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign score_o     = out_score_q;
  assign err_o       = out_err_q;

  a_sig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !raw_i |=> out_score_q[31:16] == '0)
    else $error("sigmoid result out of Q0.16 range");

endmodule

`default_nettype wire

>>> src/logistic_regression_score_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Logistic regression scorer. Load beats (tuser 0) write Q8.8 coefficients into a
// MaxDim-entry store; feature beats (tuser 1) are multiplied by the coefficient at
// their position in the vector and accumulated in Q16.16. The beat with tlast
// closes the vector and yields one result: the biased score saturated to 32 bits,
// or its sigmoid in Q0.16 from a 256-entry table, with tuser flagging a length
// mismatch against the dimension register. One beat is accepted per clock while
// s_axis_tready is high; the single read port of the coefficient store, read at
// accept time, sets that rate. A result passes the input, product, sum, bias,
// table-index and output registers after its last feature beat is accepted. The
// store is not cleared at reset: every coefficient used must be loaded first.
module logistic_regression_score_core #(
  parameter int unsigned MaxDim = lrs_pkg::MAX_DIM
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [23:0]                       s_axis_tdata,  // index[5:0], value[21:6]
  input  logic                              s_axis_tuser,  // command
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [31:0]                       m_axis_tdata,  // score[31:0]
  output logic                              m_axis_tuser,  // length_error
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lrs_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [lrs_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  import lrs_pkg::*;

  localparam int unsigned AddrW  = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int unsigned CntMax = 127;

  logic [6:0]         dim_q;
  logic signed [31:0] bias_q;
  logic               raw_q;
  logic [6:0]         cnt_q;
  logic [6:0]         cnt_inc;
  logic               s1_valid_q;
  feat_t              s1_q;
  feat_t              s1_d;
  logic               s1_ready;
  logic [5:0]         idx;
  logic signed [15:0] value;
  logic               is_feat;
  logic               in_fire;
  logic               pos_ok;
  logic               mem_we;
  logic               mem_re;
  logic signed [15:0] coef;
  logic               sum_valid;
  logic               sum_ready;
  sum_t               sum;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q  <= 7'd1;
      bias_q <= '0;
      raw_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_DIMENSION:  dim_q  <= cfg_data_i[6:0];
        REG_BIAS:       bias_q <= cfg_data_i[31:0];
        REG_RAW_OUTPUT: raw_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign idx     = s_axis_tdata[5:0];
  assign value   = s_axis_tdata[21:6];
  assign is_feat = s_axis_tuser == CMD_FEATURE;

  assign s_axis_tready = !s1_valid_q || s1_ready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign cnt_inc = (cnt_q == 7'(CntMax)) ? cnt_q : cnt_q + 7'd1;
  assign pos_ok  = (cnt_q < dim_q) && (32'(cnt_q) < MaxDim);
  assign mem_we  = in_fire && !is_feat && (32'(idx) < MaxDim);
  assign mem_re  = in_fire && is_feat && pos_ok;

  always_comb begin
    s1_d.value  = value;
    s1_d.active = pos_ok;
    s1_d.last   = s_axis_tlast;
    s1_d.err    = cnt_inc != dim_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_fire && is_feat) begin
        cnt_q <= s_axis_tlast ? '0 : cnt_inc;
      end
      if (s_axis_tready) begin
        s1_valid_q <= in_fire && is_feat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && is_feat) begin
      s1_q <= s1_d;
    end
  end

  lrs_coef_mem #(
    .Depth (MaxDim),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'(idx)),
    .wdata_i (value),
    .re_i    (mem_re),
    .raddr_i (AddrW'(cnt_q)),
    .rdata_o (coef)
  );

  lrs_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_ready_o  (s1_ready),
    .in_i        (s1_q),
    .coef_i      (coef),
    .out_valid_o (sum_valid),
    .out_ready_i (sum_ready),
    .out_o       (sum)
  );

  lrs_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sum_valid),
    .in_ready_o  (sum_ready),
    .in_i        (sum),
    .bias_i      (bias_q),
    .raw_i       (raw_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .score_o     (m_axis_tdata),
    .err_o       (m_axis_tuser)
  );

  a_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_feat && s_axis_tlast |=> cnt_q == '0)
    else $error("element count not cleared after end of vector");

  a_coef_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_ready |=> $stable(coef) && $stable(s1_q))
    else $error("coefficient read lost during stall");

endmodule

`default_nettype wire
